FILE: hw/rtl/sqf_pkg.sv
// Shared constants, operation codes and pipeline control type for the Q-format ALU.
`timescale 1ns / 1ps

package sqf_pkg;

   localparam int WORD_WIDTH_DEFAULT    = 16;
   localparam int FRACTION_BITS_DEFAULT = 4;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] operation;
      logic       negate;
      logic       div_zero;
   } ctl_type;

endpackage

FILE: hw/rtl/sqf_front.sv
// Input register with multiply, then add/multiply finish and divider load stage.
`timescale 1ns / 1ps

module sqf_front #(
   parameter int WORD_WIDTH    = sqf_pkg::WORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = sqf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   req_valid,
   input  logic [1:0]                             req_operation,
   input  logic signed [WORD_WIDTH-1:0]           req_operand_a,
   input  logic signed [WORD_WIDTH-1:0]           req_operand_b,
   output sqf_pkg::ctl_type                       cell_ctl,
   output logic [WORD_WIDTH+FRACTION_BITS-1:0]    cell_work,
   output logic [WORD_WIDTH-1:0]                  cell_divisor
);

   localparam int WORK_WIDTH = WORD_WIDTH + FRACTION_BITS;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam logic [PROD_WIDTH-1:0] HALF_LSB = PROD_WIDTH'(1) << (FRACTION_BITS - 1);
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   logic                          a_valid_ff;
   logic [1:0]                    a_op_ff;
   logic signed [WORD_WIDTH:0]    a_sum_ff;
   logic signed [PROD_WIDTH-1:0]  a_prod_ff;
   logic signed [WORK_WIDTH:0]    a_num_ff;
   logic [WORD_WIDTH-1:0]         a_divisor_ff;

   logic signed [WORD_WIDTH:0]    a_sum_in;
   logic signed [PROD_WIDTH-1:0]  a_prod_in;
   logic signed [WORK_WIDTH:0]    num_base;
   logic signed [WORK_WIDTH:0]    num_half;
   logic signed [WORK_WIDTH:0]    a_num_in;

   sqf_pkg::ctl_type              b_ctl_ff;
   sqf_pkg::ctl_type              b_ctl_in;
   logic [WORK_WIDTH-1:0]         b_work_ff;
   logic [WORK_WIDTH-1:0]         b_work_in;
   logic [WORD_WIDTH-1:0]         b_divisor_ff;
   logic [WORD_WIDTH-1:0]         b_divisor_in;

   logic                          sum_ovf;
   logic [WORD_WIDTH-1:0]         sum_val;
   logic signed [PROD_WIDTH-1:0]  rounded;
   logic [PROD_WIDTH-FRACTION_BITS-WORD_WIDTH:0] rounded_top;
   logic                          mul_ovf;
   logic [WORD_WIDTH-1:0]         mul_val;
   logic [WORK_WIDTH:0]           num_neg;
   logic [WORK_WIDTH-1:0]         num_mag;
   logic [WORD_WIDTH-1:0]         divisor_neg;
   logic                          divisor_zero;

   assign a_sum_in  = {req_operand_a[WORD_WIDTH-1], req_operand_a}
                    + {req_operand_b[WORD_WIDTH-1], req_operand_b};
   assign a_prod_in = req_operand_a * req_operand_b;
   assign num_base  = {req_operand_a[WORD_WIDTH-1], req_operand_a, {FRACTION_BITS{1'b0}}};
   assign num_half  = {{(FRACTION_BITS+2){req_operand_b[WORD_WIDTH-1]}},
                       req_operand_b[WORD_WIDTH-1:1]};
   assign a_num_in  = (req_operand_a[WORD_WIDTH-1] == req_operand_b[WORD_WIDTH-1]) ?
                      num_base + num_half : num_base - num_half;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff      <= req_operation;
         a_sum_ff     <= a_sum_in;
         a_prod_ff    <= a_prod_in;
         a_num_ff     <= a_num_in;
         a_divisor_ff <= req_operand_b;
      end
   end

   assign sum_ovf = a_sum_ff[WORD_WIDTH] != a_sum_ff[WORD_WIDTH-1];
   assign sum_val = sum_ovf ? (a_sum_ff[WORD_WIDTH] ? WORD_MIN : WORD_MAX)
                            : a_sum_ff[WORD_WIDTH-1:0];

   assign rounded     = a_prod_ff + $signed(HALF_LSB);
   assign rounded_top = rounded[PROD_WIDTH-1:FRACTION_BITS+WORD_WIDTH-1];
   assign mul_ovf     = !((&rounded_top) || !(|rounded_top));
   assign mul_val     = mul_ovf ? (rounded[PROD_WIDTH-1] ? WORD_MIN : WORD_MAX)
                                : rounded[FRACTION_BITS+WORD_WIDTH-1:FRACTION_BITS];

   assign num_neg      = -a_num_ff;
   assign num_mag      = a_num_ff[WORK_WIDTH] ? num_neg[WORK_WIDTH-1:0]
                                              : a_num_ff[WORK_WIDTH-1:0];
   assign divisor_neg  = -a_divisor_ff;
   assign divisor_zero = a_divisor_ff == '0;

   always_comb begin
      b_ctl_in.valid     = a_valid_ff;
      b_ctl_in.operation = a_op_ff;
      b_ctl_in.negate    = a_num_ff[WORK_WIDTH] ^ a_divisor_ff[WORD_WIDTH-1];
      b_ctl_in.div_zero  = 1'b0;
      b_divisor_in       = a_divisor_ff[WORD_WIDTH-1] ? divisor_neg : a_divisor_ff;
      unique case (a_op_ff)
         sqf_pkg::OP_ADD: begin
            b_work_in = WORK_WIDTH'({sum_ovf, sum_val});
         end
         sqf_pkg::OP_MUL: begin
            b_work_in = WORK_WIDTH'({mul_ovf, mul_val});
         end
         sqf_pkg::OP_DIV: begin
            b_ctl_in.div_zero = divisor_zero;
            b_work_in         = divisor_zero ? '0 : num_mag;
         end
         default: begin
            b_work_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (advance) begin
         b_ctl_ff <= b_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_work_ff          <= b_work_in;
         b_divisor_ff       <= b_divisor_in;
      end
   end

   assign cell_ctl     = b_ctl_ff;
   assign cell_work    = b_work_ff;
   assign cell_divisor = b_divisor_ff;

endmodule

FILE: hw/rtl/sqf_cell.sv
// One restoring divider cell: develops one quotient bit and passes the beat on.
`timescale 1ns / 1ps

module sqf_cell #(
   parameter int WORD_WIDTH = sqf_pkg::WORD_WIDTH_DEFAULT,
   parameter int WORK_WIDTH = sqf_pkg::WORD_WIDTH_DEFAULT + sqf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sqf_pkg::ctl_type       in_ctl,
   input  logic [WORK_WIDTH-1:0]  in_work,
   input  logic [WORD_WIDTH-2:0]  in_rem,
   input  logic [WORD_WIDTH-1:0]  in_divisor,
   output sqf_pkg::ctl_type       out_ctl,
   output logic [WORK_WIDTH-1:0]  out_work,
   output logic [WORD_WIDTH-2:0]  out_rem,
   output logic [WORD_WIDTH-1:0]  out_divisor
);

   sqf_pkg::ctl_type       ctl_ff;
   logic [WORK_WIDTH-1:0]  work_ff;
   logic [WORK_WIDTH-1:0]  work_in;
   logic [WORD_WIDTH-2:0]  rem_ff;
   logic [WORD_WIDTH-2:0]  rem_in;
   logic [WORD_WIDTH-1:0]  divisor_ff;

   logic                   step;
   logic [WORD_WIDTH-1:0]  trial;
   logic [WORD_WIDTH-1:0]  diff;
   logic                   fits;

   assign step  = (in_ctl.operation == sqf_pkg::OP_DIV) && !in_ctl.div_zero;
   assign trial = {in_rem, in_work[WORK_WIDTH-1]};
   assign fits  = trial >= in_divisor;
   assign diff  = trial - in_divisor;

   assign rem_in  = step ? (fits ? diff[WORD_WIDTH-2:0] : trial[WORD_WIDTH-2:0]) : in_rem;
   assign work_in = step ? {in_work[WORK_WIDTH-2:0], fits} : in_work;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff          <= work_in;
         rem_ff           <= rem_in;
         divisor_ff       <= in_divisor;
      end
   end

   assign out_ctl     = ctl_ff;
   assign out_work    = work_ff;
   assign out_rem     = rem_ff;
   assign out_divisor = divisor_ff;

endmodule

FILE: hw/rtl/sqf_out.sv
// Quotient sign and clamp, result register and skid stage on the response channel.
`timescale 1ns / 1ps

module sqf_out #(
   parameter int WORD_WIDTH = sqf_pkg::WORD_WIDTH_DEFAULT,
   parameter int WORK_WIDTH = sqf_pkg::WORD_WIDTH_DEFAULT + sqf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sqf_pkg::ctl_type       in_ctl,
   input  logic [WORK_WIDTH-1:0]  in_work,
   output logic                   advance,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [WORD_WIDTH-1:0]  rsp_result_value,
   output logic                   rsp_saturated,
   output logic                   rsp_divide_by_zero
);

   localparam int BEAT_WIDTH = WORD_WIDTH + 2;
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   logic                   quotient_sel;
   logic [WORD_WIDTH-1:0]  q_low;
   logic [WORD_WIDTH-1:0]  q_neg;
   logic                   pos_sat;
   logic                   neg_sat;
   logic [WORD_WIDTH-1:0]  value;
   logic                   sat;
   logic [BEAT_WIDTH-1:0]  beat;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [BEAT_WIDTH-1:0]  out_beat_ff;
   logic [BEAT_WIDTH-1:0]  out_beat_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   logic [BEAT_WIDTH-1:0]  skid_beat_ff;

   assign quotient_sel = (in_ctl.operation == sqf_pkg::OP_DIV) && !in_ctl.div_zero;
   assign q_low        = in_work[WORD_WIDTH-1:0];
   assign q_neg        = -q_low;
   assign pos_sat      = |in_work[WORK_WIDTH-1:WORD_WIDTH-1];
   assign neg_sat      = (|in_work[WORK_WIDTH-1:WORD_WIDTH])
                       || (in_work[WORD_WIDTH-1] && (|in_work[WORD_WIDTH-2:0]));

   always_comb begin
      if (!quotient_sel) begin
         sat   = in_work[WORD_WIDTH];
         value = q_low;
      end else if (in_ctl.negate) begin
         sat   = neg_sat;
         value = neg_sat ? WORD_MIN : q_neg;
      end else begin
         sat   = pos_sat;
         value = pos_sat ? WORD_MAX : q_low;
      end
   end

   assign beat    = {value, sat, in_ctl.div_zero};
   assign advance = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_ctl.valid) begin
         if (out_valid_ff && rsp_stall) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
            out_beat_in  = beat;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_beat_ff <= out_beat_in;
      if (!skid_valid_ff) begin
         skid_beat_ff <= beat;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_beat_ff[BEAT_WIDTH-1:2];
   assign rsp_saturated      = out_beat_ff[1];
   assign rsp_divide_by_zero = out_beat_ff[0];

endmodule

FILE: hw/rtl/saturating_q_format_alu_core.sv
// Top level of the saturating Q-format add/multiply/divide unit.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_operation, req_operand_a, req_operand_b
//  rsp     | out       | rsp_valid/rsp_stall | rsp_result_value, rsp_saturated,
//          |           |                     | rsp_divide_by_zero
//
// One beat per cycle in each direction while no stall holds the pipe. The row of divider cells
// develops the quotient, one quotient bit per cell.
// Reset clears all valid bits; nothing else needs clearing.
// rsp_stall fills a one-beat skid stage; req_stall rises only once that stage holds a beat,
// and the whole pipe holds until it drains.
`timescale 1ns / 1ps

module saturating_q_format_alu_core #(
   parameter int WORD_WIDTH    = sqf_pkg::WORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = sqf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic signed [WORD_WIDTH-1:0] req_operand_a,
   input  logic signed [WORD_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_result_value,
   output logic                         rsp_saturated,
   output logic                         rsp_divide_by_zero
);

   localparam int WORK_WIDTH = WORD_WIDTH + FRACTION_BITS;
   localparam int CELL_COUNT = WORK_WIDTH;

   logic                   advance;
   sqf_pkg::ctl_type       chain_ctl     [0:CELL_COUNT];
   logic [WORK_WIDTH-1:0]  chain_work    [0:CELL_COUNT];
   logic [WORD_WIDTH-2:0]  chain_rem     [0:CELL_COUNT];
   logic [WORD_WIDTH-1:0]  chain_divisor [0:CELL_COUNT];
   logic [WORD_WIDTH-1:0]  result_value;

   assign req_stall    = !advance;
   assign chain_rem[0] = '0;

   sqf_front #(
      .WORD_WIDTH    (WORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .cell_ctl      (chain_ctl[0]),
      .cell_work     (chain_work[0]),
      .cell_divisor  (chain_divisor[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      sqf_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .WORK_WIDTH (WORK_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_ctl      (chain_ctl[i]),
         .in_work     (chain_work[i]),
         .in_rem      (chain_rem[i]),
         .in_divisor  (chain_divisor[i]),
         .out_ctl     (chain_ctl[i+1]),
         .out_work    (chain_work[i+1]),
         .out_rem     (chain_rem[i+1]),
         .out_divisor (chain_divisor[i+1])
      );
   end

   sqf_out #(
      .WORD_WIDTH (WORD_WIDTH),
      .WORK_WIDTH (WORK_WIDTH)
   ) u_out (
      .clock              (clock),
      .reset              (reset),
      .in_ctl             (chain_ctl[CELL_COUNT]),
      .in_work            (chain_work[CELL_COUNT]),
      .advance            (advance),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_value   (result_value),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   assign rsp_result_value = $signed(result_value);

endmodule

FILE: hw/rtl/sqf_checker.sv
// Port-level checks for the Q-format ALU and their bind to the top level.
`timescale 1ns / 1ps

module sqf_checker #(
   parameter int WORD_WIDTH = sqf_pkg::WORD_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WORD_WIDTH-1:0] rsp_result_value,
   input logic                  rsp_saturated,
   input logic                  rsp_divide_by_zero
);

   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_saturated) && $stable(rsp_divide_by_zero))
      else $error("stalled response beat changed");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_value == '0 && !rsp_saturated)
      else $error("divide by zero beat not zero and unsaturated");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_result_value == WORD_MIN || rsp_result_value == WORD_MAX)
      else $error("saturated beat not at a range bound");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not idle after reset");

endmodule

bind saturating_q_format_alu_core sqf_checker #(
   .WORD_WIDTH (WORD_WIDTH)
) u_sqf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_value   (rsp_result_value),
   .rsp_saturated      (rsp_saturated),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

FILE: tb/sqf_result_checker.sv
// Checker that predicts each Q-format ALU result from the request beats and compares the responses.
`timescale 1ns / 1ps

module sqf_result_checker #(
   parameter int WW = sqf_pkg::WORD_WIDTH_DEFAULT,
   parameter int FB = sqf_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic signed [WW-1:0] req_operand_a,
   input  logic signed [WW-1:0] req_operand_b,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [WW-1:0] rsp_result_value,
   input  logic                 rsp_saturated,
   input  logic                 rsp_divide_by_zero,
   output int                   mismatch_count,
   output int                   outstanding
);

   typedef struct packed {
      logic signed [WW-1:0] value;
      logic                 saturated;
      logic                 div_zero;
   } q_result_type;

   localparam longint Q_MAX_L = (longint'(1) <<< (WW - 1)) - 1;
   localparam longint Q_MIN_L = -(longint'(1) <<< (WW - 1));
   localparam longint HALF_LSB = longint'(1) <<< (FB - 1);

   q_result_type pending_results[$];
   int           err_cnt = 0;

   assign mismatch_count = err_cnt;

   function automatic q_result_type predict_q_result(logic [1:0] op,
                                                     logic signed [WW-1:0] a,
                                                     logic signed [WW-1:0] b);
      longint       sa;
      longint       sb;
      longint       exact;
      q_result_type r;
      sa    = longint'(a);
      sb    = longint'(b);
      exact = 0;
      r     = '0;
      case (op)
         sqf_pkg::OP_ADD: begin
            exact = sa + sb;
         end
         sqf_pkg::OP_MUL: begin
            exact = (sa * sb + HALF_LSB) >>> FB;
         end
         sqf_pkg::OP_DIV: begin
            if (sb == 0) begin
               r.div_zero = 1'b1;
            end else begin
               exact = sa * (longint'(1) <<< FB);
               if ((exact >= 0) == (sb >= 0)) begin
                  exact = exact + (sb >>> 1);
               end else begin
                  exact = exact - (sb >>> 1);
               end
               exact = exact / sb;
            end
         end
         default: begin
         end
      endcase
      if (exact > Q_MAX_L) begin
         r.saturated = 1'b1;
         r.value     = Q_MAX_L[WW-1:0];
      end else if (exact < Q_MIN_L) begin
         r.saturated = 1'b1;
         r.value     = Q_MIN_L[WW-1:0];
      end else begin
         r.value = exact[WW-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      q_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response beat with no pending result: value %0d", rsp_result_value);
               err_cnt++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d", want.value,
                         rsp_result_value);
                  err_cnt++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b", want.saturated,
                         rsp_saturated);
                  err_cnt++;
               end
               if (rsp_divide_by_zero !== want.div_zero) begin
                  $error("divide_by_zero: expected %0b, actual %0b", want.div_zero,
                         rsp_divide_by_zero);
                  err_cnt++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(predict_q_result(req_operation, req_operand_a,
                                                       req_operand_b));
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

FILE: tb/tb_saturating_q_format_alu_core.sv
// Testbench top: drives operand beats and response stalls into the Q-format ALU and reports.
`timescale 1ns / 1ps

module tb_saturating_q_format_alu_core;

   localparam int WW           = sqf_pkg::WORD_WIDTH_DEFAULT;
   localparam int FB           = sqf_pkg::FRACTION_BITS_DEFAULT;
   localparam int LATENCY      = WW + FB + 2;
   localparam int RANDOM_BEATS = 1500;
   localparam int IDLE_PCT     = 9;
   localparam int QUIET_FIRST  = 200;
   localparam int QUIET_LAST   = 500;
   localparam int HOLD_AT      = 900;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [WW-1:0] Q_MAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] Q_MIN = {1'b1, {(WW-1){1'b0}}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_operation = sqf_pkg::OP_ADD;
   logic signed [WW-1:0] req_operand_a = '0;
   logic signed [WW-1:0] req_operand_b = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [WW-1:0] rsp_result_value;
   logic                 rsp_saturated;
   logic                 rsp_divide_by_zero;

   int mismatch_count;
   int outstanding;
   int req_count = 0;
   bit hold_done = 1'b0;

   saturating_q_format_alu_core #(
      .WORD_WIDTH(WW),
      .FRACTION_BITS(FB)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_saturated(rsp_saturated),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   sqf_result_checker #(
      .WW(WW),
      .FB(FB)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_saturated(rsp_saturated),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         req_count <= req_count + 1;
      end
   end

   function automatic bit quiet_window();
      return req_count >= QUIET_FIRST && req_count < QUIET_LAST;
   endfunction

   function automatic logic signed [WW-1:0] pick_operand();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return WW'($urandom);
      end else if (roll < 60) begin
         return WW'($urandom_range(0, 511) - 256);
      end else if (roll < 70) begin
         case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return WW'(1);
            4: return WW'(-1);
            default: return Q_MAX - WW'(1);
         endcase
      end
      return WW'($urandom_range(0, 8191) - 4096);
   endfunction

   function automatic logic [1:0] pick_operation();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         return sqf_pkg::OP_ADD;
      end else if (roll < 62) begin
         return sqf_pkg::OP_MUL;
      end else if (roll < 95) begin
         return sqf_pkg::OP_DIV;
      end
      return OP_UNUSED;
   endfunction

   // hold the beat until accepted; idle beforehand at random outside the quiet window
   task automatic offer_operands(input logic [1:0] op, input logic signed [WW-1:0] a,
                                 input logic signed [WW-1:0] b);
      while (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && req_count >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [1:0]           op;
      logic signed [WW-1:0] a;
      logic signed [WW-1:0] b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_operands(sqf_pkg::OP_ADD, Q_MAX, Q_MAX);
      offer_operands(sqf_pkg::OP_ADD, Q_MIN, Q_MIN);
      offer_operands(sqf_pkg::OP_ADD, Q_MAX, Q_MIN);
      offer_operands(sqf_pkg::OP_ADD, Q_MAX, '0);
      offer_operands(sqf_pkg::OP_ADD, Q_MIN, '0);
      offer_operands(sqf_pkg::OP_MUL, Q_MIN, Q_MIN);
      offer_operands(sqf_pkg::OP_MUL, Q_MIN, Q_MAX);
      offer_operands(sqf_pkg::OP_MUL, Q_MAX, Q_MAX);
      offer_operands(sqf_pkg::OP_MUL, WW'(16), WW'(16));
      offer_operands(sqf_pkg::OP_MUL, WW'(8), WW'(1));
      offer_operands(sqf_pkg::OP_MUL, WW'(-8), WW'(1));
      offer_operands(sqf_pkg::OP_MUL, WW'(-1), WW'(1));
      offer_operands(sqf_pkg::OP_DIV, WW'(1), '0);
      offer_operands(sqf_pkg::OP_DIV, Q_MIN, '0);
      offer_operands(sqf_pkg::OP_DIV, Q_MIN, WW'(-1));
      offer_operands(sqf_pkg::OP_DIV, Q_MAX, WW'(1));
      offer_operands(sqf_pkg::OP_DIV, '0, WW'(5));
      offer_operands(sqf_pkg::OP_DIV, WW'(1), WW'(-3));
      offer_operands(sqf_pkg::OP_DIV, WW'(-1), WW'(3));
      offer_operands(sqf_pkg::OP_DIV, Q_MIN, Q_MIN);
      offer_operands(sqf_pkg::OP_DIV, WW'(-7), WW'(2));
      offer_operands(OP_UNUSED, Q_MAX, Q_MIN);
      offer_operands(OP_UNUSED, 16'hAAAA, 16'h5555);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         op = pick_operation();
         a  = pick_operand();
         b  = pick_operand();
         if (op == sqf_pkg::OP_DIV && $urandom_range(0, 19) == 0) begin
            b = '0;
         end
         offer_operands(op, a, b);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 8) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
